// ===== hdl/qpr_pkg.sv =====
// Shared constants and term-selection tables for the quaternion point rotation.
`default_nettype none

package qpr_pkg;

  localparam int QUAT_BITS  = 16;
  localparam int SPLIT_BITS = 16;

  // conj(q) * p : row = t component (w,x,y,z), column = point component (x,y,z)
  localparam logic [1:0] P1_QSEL [4][3] = '{
    '{2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd0}
  };
  localparam logic P1_NEG [4][3] = '{
    '{1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1},
    '{1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0}
  };

  // t * q : row = result component (x,y,z), column = q component (w,x,y,z)
  localparam logic [1:0] P2_TSEL [3][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic P2_NEG [3][4] = '{
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0}
  };

endpackage

`default_nettype wire

// ===== hdl/qpr_split_mul.sv =====
// Two-stage signed multiplier of a wide operand by a quaternion component.
`default_nettype none

module qpr_split_mul
  import qpr_pkg::*;
#(
  parameter int TW = 34
) (
  input  wire logic                          clk,
  input  wire logic                          en_i,
  input  wire logic signed [TW-1:0]          t_i,
  input  wire logic signed [QUAT_BITS-1:0]   q_i,
  output logic signed [TW+QUAT_BITS-1:0]     prod_o
);

  localparam int HW = TW - SPLIT_BITS;
  localparam int PW = TW + QUAT_BITS;
  localparam int LW = SPLIT_BITS + 1 + QUAT_BITS;

  logic signed [HW-1:0]           hi_s;
  logic signed [SPLIT_BITS:0]     lo_s;
  logic signed [TW-1:0]           prod_hi_nxt, prod_hi_r;
  logic signed [LW-1:0]           prod_lo_nxt, prod_lo_r;
  logic signed [PW-1:0]           prod_nxt, prod_r;

  always_comb begin
    hi_s        = t_i[TW-1:SPLIT_BITS];
    lo_s        = {1'b0, t_i[SPLIT_BITS-1:0]};
    prod_hi_nxt = hi_s * q_i;
    prod_lo_nxt = lo_s * q_i;
    prod_nxt    = (PW'(prod_hi_r) <<< SPLIT_BITS) + PW'(prod_lo_r);
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      prod_hi_r <= prod_hi_nxt;
      prod_lo_r <= prod_lo_nxt;
      prod_r    <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule

`default_nettype wire

// ===== hdl/qpr_round_sat.sv =====
// Final scaling shift and saturation of one rotated coordinate.
`default_nettype none

module qpr_round_sat #(
  parameter int SW = 64,
  parameter int FS = 28,
  parameter int CB = 16
) (
  input  wire logic signed [SW-1:0] sum_i,
  output logic signed [CB-1:0]      val_o,
  output logic                      clip_o
);

  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (CB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (CB - 1));

  logic signed [SW-1:0] shifted;
  logic                 over;
  logic                 under;

  always_comb begin
    shifted = sum_i >>> FS;
    over    = shifted > MAXV;
    under   = shifted < MINV;
    clip_o  = over | under;
    if (over) begin
      val_o = MAXV[CB-1:0];
    end else if (under) begin
      val_o = MINV[CB-1:0];
    end else begin
      val_o = shifted[CB-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/quaternion_point_rotation.sv =====
// Quaternion point rotation: conj(q) * p * q, rounded and saturated.
// Path of an input beat: prod1_r, t2_r, multiplier registers, sum5_r, output register.
// One beat per cycle unless stalled; a two-entry output buffer registers in_tready.
// Output stall: the pipeline freezes once the skid entry fills; nothing is lost.
// Reset: synchronous, clears all valid bits; in_tready rises the cycle after reset ends.
`default_nettype none

module quaternion_point_rotation
  import qpr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int COORD_BITS     = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          in_tvalid,
  output logic                                               in_tready,
  // rot_w, rot_x, rot_y, rot_z, point_x, point_y, point_z, zero pad
  input  wire logic [((4*QUAT_BITS+3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                                               out_tvalid,
  input  wire logic                                          out_tready,
  // out_x, out_y, out_z, zero pad
  output logic [((3*COORD_BITS+7)/8)*8-1:0]                  out_tdata,
  // clipped
  output logic                                               out_tuser
);

  localparam int C        = COORD_BITS;
  localparam int QB       = QUAT_BITS;
  localparam int PW1      = QB + C;
  localparam int MID_DROP = (C > 29) ? C - 29 : 0;
  localparam int TW0      = C + QB + 2;
  localparam int TW       = TW0 - MID_DROP;
  localparam int FS       = 2 * QUAT_FRAC_BITS - MID_DROP;
  localparam int RW       = TW + QB;
  localparam int SW       = (RW > FS) ? RW + 2 : FS + 2;

  localparam logic signed [TW0-1:0] MID_HALF =
    (MID_DROP > 0) ? (TW0'(1) <<< ((MID_DROP > 0) ? MID_DROP - 1 : 0)) : '0;
  localparam logic signed [SW-1:0]  FINAL_HALF = SW'(1) <<< (FS - 1);

  logic                    en;
  logic                    in_fire;
  logic [4:0]              vld_r;

  logic signed [QB-1:0]    rot_in   [4];
  logic signed [C-1:0]     point_in [3];

  logic signed [PW1-1:0]   prod1_r  [4][3];
  logic signed [QB-1:0]    q1_r     [4];
  logic signed [TW-1:0]    t2_nxt   [4];
  logic signed [TW-1:0]    t2_r     [4];
  logic signed [QB-1:0]    q2_r     [4];
  logic signed [RW-1:0]    prod4    [3][4];
  logic signed [SW-1:0]    sum5_nxt [3];
  logic signed [SW-1:0]    sum5_r   [3];

  logic signed [C-1:0]     res_val  [3];
  logic [2:0]              res_clip;
  logic [3*C-1:0]          res_data;
  logic                    push;

  logic [3*C-1:0]          out_data_r, out_data_nxt;
  logic                    out_clip_r, out_clip_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic [3*C-1:0]          skid_data_r, skid_data_nxt;
  logic                    skid_clip_r, skid_clip_nxt;
  logic                    skid_vld_r, skid_vld_nxt;
  logic                    in_rdy_r, in_rdy_nxt;

  assign en      = in_rdy_r;
  assign in_fire = in_tvalid & in_rdy_r;
  assign push    = en & vld_r[4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rot_in[k] = in_tdata[k*QB +: QB];
    end
    for (int j = 0; j < 3; j++) begin
      point_in[j] = in_tdata[4*QB + j*C +: C];
    end
  end

  // stage 2: first Hamilton product sums, optional mid rounding
  always_comb begin
    logic signed [TW0-1:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = MID_HALF;
      for (int j = 0; j < 3; j++) begin
        if (P1_NEG[r][j]) begin
          acc = acc - TW0'(prod1_r[r][j]);
        end else begin
          acc = acc + TW0'(prod1_r[r][j]);
        end
      end
      t2_nxt[r] = TW'(acc >>> MID_DROP);
    end
  end

  // stages 3-4: second Hamilton product terms
  for (genvar c = 0; c < 3; c++) begin : g_row
    for (genvar k = 0; k < 4; k++) begin : g_term
      qpr_split_mul #(
        .TW (TW)
      ) u_mul (
        .clk    (clk),
        .en_i   (en),
        .t_i    (t2_r[P2_TSEL[c][k]]),
        .q_i    (q2_r[k]),
        .prod_o (prod4[c][k])
      );
    end
  end

  // stage 5: final sums with rounding offset
  always_comb begin
    logic signed [SW-1:0] acc;
    for (int c = 0; c < 3; c++) begin
      acc = FINAL_HALF;
      for (int k = 0; k < 4; k++) begin
        if (P2_NEG[c][k]) begin
          acc = acc - SW'(prod4[c][k]);
        end else begin
          acc = acc + SW'(prod4[c][k]);
        end
      end
      sum5_nxt[c] = acc;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_out
    qpr_round_sat #(
      .SW (SW),
      .FS (FS),
      .CB (C)
    ) u_rsat (
      .sum_i  (sum5_r[c]),
      .val_o  (res_val[c]),
      .clip_o (res_clip[c])
    );
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res_data[c*C +: C] = res_val[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod1_r[r][j] <= rot_in[P1_QSEL[r][j]] * point_in[j];
        end
      end
      q1_r   <= rot_in;
      t2_r   <= t2_nxt;
      q2_r   <= q1_r;
      sum5_r <= sum5_nxt;
    end
  end

  // output register plus skid entry
  always_comb begin
    out_data_nxt  = out_data_r;
    out_clip_nxt  = out_clip_r;
    out_vld_nxt   = out_vld_r;
    skid_data_nxt = skid_data_r;
    skid_clip_nxt = skid_clip_r;
    skid_vld_nxt  = skid_vld_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_data_nxt = skid_data_r;
        out_clip_nxt = skid_clip_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_data_nxt = res_data;
        out_clip_nxt = |res_clip;
        out_vld_nxt  = push;
      end
    end else if (push) begin
      skid_data_nxt = res_data;
      skid_clip_nxt = |res_clip;
      skid_vld_nxt  = 1'b1;
    end
    in_rdy_nxt = ~skid_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
      in_rdy_r   <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[3:0], in_fire};
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
      in_rdy_r   <= in_rdy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_clip_r  <= out_clip_nxt;
    skid_data_r <= skid_data_nxt;
    skid_clip_r <= skid_clip_nxt;
  end

  always_comb begin
    out_tdata            = '0;
    out_tdata[3*C-1:0]   = out_data_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_clip_r;
  assign in_tready  = in_rdy_r;

endmodule

`default_nettype wire

// ===== dv/quaternion_point_rotation_test.sv =====
// Self-checking stream testbench for the quaternion point rotation block.
`timescale 1ns / 100ps

module quaternion_point_rotation_test;
  import qpr_pkg::*;

  localparam int COORD_W      = 16;
  localparam int FRAC_W       = 14;
  localparam int RANDOM_BEATS = 1900;
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));

  // packed high to low so that rot_w lands in the lowest bits of tdata
  typedef struct packed {
    logic signed [COORD_W-1:0]   pz;
    logic signed [COORD_W-1:0]   py;
    logic signed [COORD_W-1:0]   px;
    logic signed [QUAT_BITS-1:0] qz;
    logic signed [QUAT_BITS-1:0] qy;
    logic signed [QUAT_BITS-1:0] qx;
    logic signed [QUAT_BITS-1:0] qw;
  } pose_beat_t;

  typedef struct packed {
    logic                      clipped;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } rotated_point_t;

  typedef struct {
    longint w, x, y, z;
  } quat_wide_t;

  class rotation_scoreboard;
    rotated_point_t pending_q[$];
    int errors;
    int results_seen;

    function new();
      errors = 0;
      results_seen = 0;
    endfunction

    function quat_wide_t quat_mul(quat_wide_t a, quat_wide_t b);
      quat_wide_t r;
      r.w = a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z;
      r.x = a.x * b.w + a.w * b.x - a.z * b.y + a.y * b.z;
      r.y = a.y * b.w + a.z * b.x + a.w * b.y - a.x * b.z;
      r.z = a.z * b.w - a.y * b.x + a.x * b.y + a.w * b.z;
      return r;
    endfunction

    // round half up out of the Q2.28 product, then clamp
    function logic signed [COORD_W-1:0] round_clamp(longint v, inout logic clip);
      longint s;
      s = (v + (64'sd1 <<< (2 * FRAC_W - 1))) >>> (2 * FRAC_W);
      if (s > COORD_MAX) begin
        clip = 1'b1;
        s = COORD_MAX;
      end else if (s < COORD_MIN) begin
        clip = 1'b1;
        s = COORD_MIN;
      end
      return s[COORD_W-1:0];
    endfunction

    function rotated_point_t rotate(pose_beat_t b);
      quat_wide_t q, qc, p, t, r;
      rotated_point_t o;
      logic clip;
      q.w = longint'($signed(b.qw));
      q.x = longint'($signed(b.qx));
      q.y = longint'($signed(b.qy));
      q.z = longint'($signed(b.qz));
      qc.w = q.w;
      qc.x = -q.x;
      qc.y = -q.y;
      qc.z = -q.z;
      p.w = 0;
      p.x = longint'($signed(b.px));
      p.y = longint'($signed(b.py));
      p.z = longint'($signed(b.pz));
      t = quat_mul(qc, p);
      r = quat_mul(t, q);
      clip = 1'b0;
      o.x = round_clamp(r.x, clip);
      o.y = round_clamp(r.y, clip);
      o.z = round_clamp(r.z, clip);
      o.clipped = clip;
      return o;
    endfunction

    function void note_pose(pose_beat_t b);
      pending_q.push_back(rotate(b));
    endfunction

    function void check_point(rotated_point_t got);
      rotated_point_t exp_pt;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: x %0d y %0d z %0d clipped %0b",
               got.x, got.y, got.z, got.clipped);
        errors++;
        return;
      end
      exp_pt = pending_q.pop_front();
      if (got.x !== exp_pt.x) begin
        $error("out_x: expected %0d, actual %0d", exp_pt.x, got.x);
        errors++;
      end
      if (got.y !== exp_pt.y) begin
        $error("out_y: expected %0d, actual %0d", exp_pt.y, got.y);
        errors++;
      end
      if (got.z !== exp_pt.z) begin
        $error("out_z: expected %0d, actual %0d", exp_pt.z, got.z);
        errors++;
      end
      if (got.clipped !== exp_pt.clipped) begin
        $error("clipped: expected %0b, actual %0b", exp_pt.clipped, got.clipped);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         out_tuser;

  rotation_scoreboard sb = new();
  int beats_sent;

  quaternion_point_rotation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pose(pose_beat_t'(in_tdata));
    if (rst_n && out_tvalid && out_tready) sb.check_point(rotated_point_t'({out_tuser, out_tdata}));
  end

  function automatic pose_beat_t make_pose(int w, int x, int y, int z, int px, int py, int pz);
    pose_beat_t b;
    b.qw = w[QUAT_BITS-1:0];
    b.qx = x[QUAT_BITS-1:0];
    b.qy = y[QUAT_BITS-1:0];
    b.qz = z[QUAT_BITS-1:0];
    b.px = px[COORD_W-1:0];
    b.py = py[COORD_W-1:0];
    b.pz = pz[COORD_W-1:0];
    return b;
  endfunction

  function automatic int rand_coord();
    int sel;
    int vals[3] = '{-32768, 32767, 0};
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed($urandom_range(0, 65535)) - 32768;
    if (sel < 9) return $urandom_range(0, 4000) - 2000;
    return vals[$urandom_range(0, 2)];
  endfunction

  function automatic pose_beat_t rand_pose();
    pose_beat_t b;
    int kind;
    int c[4];
    real n, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) c[i] = $urandom_range(0, 32768) - 16384;
    if (kind < 6) begin
      n = $sqrt(real'(c[0]) * c[0] + real'(c[1]) * c[1] + real'(c[2]) * c[2] +
                real'(c[3]) * c[3]);
      if (n < 1.0) begin
        c[0] = 16384;
      end else begin
        k = 16384.0 / n;
        for (int i = 0; i < 4; i++)
          c[i] = $rtoi(c[i] * k + ((c[i] >= 0) ? 0.5 : -0.5));
      end
    end else if (kind >= 8) begin
      for (int i = 0; i < 4; i++) c[i] = $urandom_range(0, 65535);
    end
    b = make_pose(c[0], c[1], c[2], c[3], rand_coord(), rand_coord(), rand_coord());
    return b;
  endfunction

  task automatic send_pose(pose_beat_t b);
    int gap;
    gap = (beats_sent >= 1000 && beats_sent < 1300) ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  initial begin : result_sink
    int stall;
    bit held_off;
    out_tready = 1'b0;
    held_off = 1'b0;
    wait (rst_n);
    forever begin
      if (!held_off && sb.results_seen >= 400) begin
        held_off = 1'b1;
        repeat (300) begin
          @(negedge clk);
          out_tready = 1'b0;
        end
      end
      stall = (sb.results_seen >= 1000 && sb.results_seen < 1300) ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    pose_beat_t directed[$];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    beats_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // identity and its negation, coordinate extremes
    directed.push_back(make_pose(16384, 0, 0, 0, 32767, -32768, 0));
    directed.push_back(make_pose(16384, 0, 0, 0, -32768, 32767, 1));
    directed.push_back(make_pose(-16384, 0, 0, 0, -32768, -32768, 32767));
    // half turns about each axis
    directed.push_back(make_pose(0, 16384, 0, 0, 1000, 2000, 3000));
    directed.push_back(make_pose(0, 0, 16384, 0, 1000, 2000, 3000));
    directed.push_back(make_pose(0, 0, 0, 16384, 1000, 2000, -3000));
    directed.push_back(make_pose(0, -16384, 0, 0, -32768, 32767, -32768));
    // quarter turns and a third of a turn about the diagonal
    directed.push_back(make_pose(11585, 0, 0, 11585, 10000, 0, 0));
    directed.push_back(make_pose(11585, -11585, 0, 0, 0, 32767, -32768));
    directed.push_back(make_pose(8192, 8192, 8192, 8192, 32767, 32767, 32767));
    // non-unit quaternions, saturation in both directions
    directed.push_back(make_pose(16384, 16384, 16384, 16384, 32767, 32767, 32767));
    directed.push_back(make_pose(16384, 16384, 16384, 16384, -32768, -32768, -32768));
    directed.push_back(make_pose(16384, 16384, 0, 0, 20000, -20000, 20000));
    directed.push_back(make_pose(-32768, -32768, -32768, -32768, -32768, 32767, -32768));
    directed.push_back(make_pose(32767, 32767, 32767, 32767, 32767, -32768, 1));
    directed.push_back(make_pose(32767, -32768, 32767, -32768, -1, 1, -1));
    // zero quaternion
    directed.push_back(make_pose(0, 0, 0, 0, 32767, -32768, 12345));
    // rounding at exact halves: scale 0.25
    directed.push_back(make_pose(8192, 0, 0, 0, 2, -2, 6));
    directed.push_back(make_pose(8192, 0, 0, 0, -6, 1, -1));
    directed.push_back(make_pose(-8192, 0, 0, 0, 10, -10, 3));
    directed.push_back(make_pose(16384, 0, 0, 0, 0, 0, 0));

    foreach (directed[i]) send_pose(directed[i]);
    repeat (RANDOM_BEATS) send_pose(rand_pose());
    @(negedge clk);
    in_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
